### rtl/khce_pkg.sv
// ---------------------------------------------------------------------------
// khce_pkg: shared types and helpers for the keyframe curve evaluator
// Key record layout, sequencer states, status codes and saturation helpers.
// ---------------------------------------------------------------------------
package khce_pkg;

    localparam int MAX_KEYS   = 64;
    localparam int KEY_AW     = 6;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = 80;
    localparam int WIDE_W     = 66;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_EMPTY  = 2'd1;
    localparam logic [1:0] STAT_LOADED = 2'd2;

    localparam logic [2:0] ADDR_KEY_COUNT = 3'd0;
    localparam logic [2:0] ADDR_LOOP      = 3'd4;

    typedef struct packed {
        logic [1:0]         flags;      // [1] out step, [0] in step
        logic signed [31:0] out_slope;
        logic signed [31:0] in_slope;
        logic signed [31:0] value;
        logic signed [31:0] time_q;
    } t_key;

    localparam int KEY_W = $bits(t_key);

    typedef enum logic [4:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_WDIV,
        S_WFIX,
        S_CLAMP,
        S_SISSUE,
        S_SCMP,
        S_GETL,
        S_GETR,
        S_CHECK,
        S_M0,
        S_M1,
        S_COEF,
        S_SPREP,
        S_SDIV,
        S_HMUL,
        S_DONE
    } t_state;

    function automatic logic signed [47:0] sat48(input logic signed [WIDE_W-1:0] x);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = 66'sd140737488355327;
        lo = -66'sd140737488355328;
        if (x > hi) begin
            return 48'sh7FFF_FFFF_FFFF;
        end else if (x < lo) begin
            return 48'sh8000_0000_0000;
        end
        return x[47:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
        logic signed [47:0] hi;
        logic signed [47:0] lo;
        hi = 48'sd2147483647;
        lo = -48'sd2147483648;
        if (x > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (x < lo) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

endpackage

### rtl/khce_ram.sv
// ---------------------------------------------------------------------------
// khce_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module khce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/keyframe_hermite_curve_evaluator.sv
// ---------------------------------------------------------------------------
// keyframe_hermite_curve_evaluator: scalar Q16.16 cubic Hermite keyframe curve
// Key store in RAM, binary segment search, serial multiply and divide unit.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready): action 0 writes one key into slot
//   i_key_index, action 1 evaluates the curve at i_eval_time. Every beat gives
//   exactly one result beat on o_out_valid / i_out_ready.
//   APB port: key_count at 0x0, loop_enable at 0x4; write only while idle.
// Timing:
//   A load or an evaluate on an empty curve answers in the cycle after its beat.
//   An evaluate walks a sequencer that reads the key RAM one word per cycle:
//   up to 7 binary search steps (S_SISSUE, S_SCMP) and a closing S_SISSUE, a
//   1-bit-per-cycle divider (for the loop wrap and the segment parameter) and a
//   1-bit-per-cycle multiplier (tangent products, Horner steps). A clamped time
//   passes S_FIRST, S_LAST and S_CLAMP; the loop wrap adds S_WDIV and S_WFIX.
//   One item is in flight.
// Reset: config, state and output valid clear (no keys in use); key RAM undefined.
// Stall: a finished result waits in the output register; the next item is
//   taken once that register is free or drained in the same cycle.
// ---------------------------------------------------------------------------
module keyframe_hermite_curve_evaluator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_action,
    input  logic [5:0]         i_key_index,
    input  logic signed [31:0] i_key_time,
    input  logic signed [31:0] i_key_value,
    input  logic signed [31:0] i_key_in_slope,
    input  logic signed [31:0] i_key_out_slope,
    input  logic               i_in_is_step,
    input  logic               i_out_is_step,
    input  logic signed [31:0] i_eval_time,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_curve_value,
    output logic [1:0]         o_status,
    output logic [5:0]         o_segment_index,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    khce_pkg::t_state r_state, n_state;

    logic [6:0]  r_key_count;
    logic        r_loop;
    logic        r_out_valid;
    logic signed [31:0] r_out_value;
    logic [1:0]  r_out_status;
    logic [5:0]  r_out_seg;
    logic signed [31:0] r_res_value;
    logic [5:0]  r_res_seg;

    logic [6:0]  r_n;
    logic signed [32:0] r_t;
    logic signed [31:0] r_start, r_end, r_v0, r_vlast;
    logic [6:0]  r_first, r_count;
    logic [5:0]  r_mid, r_l, r_r;
    logic signed [31:0] r_tl, r_pl, r_ol, r_pr, r_ir;
    logic [1:0]  r_fl, r_fr;
    logic signed [32:0] r_dl;
    logic        r_neg;
    logic [32:0] r_div_r, r_div_d, r_div_v;
    logic [15:0] r_div_q;
    logic [5:0]  r_div_cnt;
    logic signed [khce_pkg::PROD_W-1:0] r_ma, r_prod;
    logic [31:0] r_mb;
    logic signed [47:0] r_m0l, r_m1l, r_ca, r_cb;
    logic [16:0] r_s;
    logic [1:0]  r_hk;

    logic        w_cfg_we, w_accept, w_out_free, w_out_load;
    logic [6:0]  w_n_in;
    logic [5:0]  w_raddr;
    logic [khce_pkg::KEY_W-1:0] w_rdata;
    khce_pkg::t_key w_key;
    logic signed [32:0] w_start, w_end, w_len, w_diff, w_rd_time, w_dt;
    logic        w_wrap;
    logic [6:0]  w_half, w_mid, w_l7, w_r7;
    logic [33:0] w_div_rn;
    logic        w_div_ge, w_div_done, w_mul_done, w_hold;
    logic [32:0] w_rem;
    logic signed [khce_pkg::PROD_W-1:0] w_prod_sh;
    logic signed [khce_pkg::WIDE_W-1:0] w_prod_fl, w_p0, w_p1, w_m0, w_m1;
    logic signed [khce_pkg::WIDE_W-1:0] w_a_sum, w_b_sum, w_h_sum, w_h_add;
    logic signed [47:0] w_h_next;

    // ---------------------------------------------------------------- config
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= '0;
            r_loop      <= 1'b0;
        end else if (w_cfg_we) begin
            if (paddr == khce_pkg::ADDR_KEY_COUNT) begin
                r_key_count <= pwdata[6:0];
            end else if (paddr == khce_pkg::ADDR_LOOP) begin
                r_loop <= pwdata[0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == khce_pkg::ADDR_KEY_COUNT) begin
            prdata = {25'd0, r_key_count};
        end else if (paddr == khce_pkg::ADDR_LOOP) begin
            prdata = {31'd0, r_loop};
        end
    end

    // ------------------------------------------------------------- key store
    khce_ram #(
        .WIDTH (khce_pkg::KEY_W),
        .DEPTH (khce_pkg::MAX_KEYS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && !i_action),
        .i_waddr (i_key_index),
        .i_wdata ({i_out_is_step, i_in_is_step, i_key_out_slope, i_key_in_slope,
                   i_key_value, i_key_time}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_key = khce_pkg::t_key'(w_rdata);

    // ---------------------------------------------------------- handshake
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == khce_pkg::S_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_n_in     = (r_key_count > 7'(khce_pkg::MAX_KEYS)) ? 7'(khce_pkg::MAX_KEYS)
                                                               : r_key_count;
    assign w_out_load = (w_accept && (!i_action || w_n_in == 7'd0)) ||
                        (r_state == khce_pkg::S_DONE && w_out_free);

    // ------------------------------------------------------ datapath helpers
    assign w_start   = {r_start[31], r_start};
    assign w_end     = {r_end[31], r_end};
    assign w_rd_time = {w_key.time_q[31], w_key.time_q};
    assign w_len     = w_rd_time - w_start;          // valid in S_LAST
    assign w_diff    = r_t - w_start;
    assign w_wrap    = r_loop && (w_len > 33'sd0) && ((r_t < w_start) || (r_t > w_rd_time));

    assign w_half = r_count >> 1;
    assign w_mid  = r_first + w_half;
    assign w_l7   = (r_first != 7'd0) ? (r_first - 7'd1) : 7'd0;
    assign w_r7   = (r_first < r_n) ? r_first : (r_n - 7'd1);

    assign w_div_rn   = {r_div_r, r_div_d[32]};
    assign w_div_ge   = w_div_rn >= {1'b0, r_div_v};
    assign w_div_done = (r_div_cnt == 6'd0);
    assign w_rem      = (r_neg && r_div_r != 33'd0) ? (r_div_v - r_div_r) : r_div_r;

    assign w_mul_done = (r_mb == 32'd0);
    assign w_prod_sh  = r_prod >>> khce_pkg::FRAC_BITS;
    assign w_prod_fl  = w_prod_sh[khce_pkg::WIDE_W-1:0];

    assign w_dt   = r_t - {r_tl[31], r_tl};
    assign w_hold = (r_dl <= 33'sd0) || r_fl[1] || r_fr[0];

    assign w_p0 = {{(khce_pkg::WIDE_W-32){r_pl[31]}}, r_pl};
    assign w_p1 = {{(khce_pkg::WIDE_W-32){r_pr[31]}}, r_pr};
    assign w_m0 = {{(khce_pkg::WIDE_W-48){r_m0l[47]}}, r_m0l};
    assign w_m1 = {{(khce_pkg::WIDE_W-48){r_m1l[47]}}, r_m1l};
    assign w_a_sum = 66'sd2 * (w_p0 - w_p1) + w_m0 + w_m1;
    assign w_b_sum = 66'sd3 * (w_p1 - w_p0) - 66'sd2 * w_m0 - w_m1;

    always_comb begin
        case (r_hk)
            2'd0:    w_h_add = {{(khce_pkg::WIDE_W-48){r_cb[47]}}, r_cb};
            2'd1:    w_h_add = w_m0;
            default: w_h_add = w_p0;
        endcase
    end
    assign w_h_sum  = w_prod_fl + w_h_add;
    assign w_h_next = khce_pkg::sat48(w_h_sum);

    // ------------------------------------------------------------ sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= khce_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_raddr = '0;
        case (r_state)
            khce_pkg::S_IDLE: begin
                if (w_accept && i_action && w_n_in != 7'd0) begin
                    n_state = khce_pkg::S_FIRST;
                end
            end
            khce_pkg::S_FIRST: begin
                w_raddr = 6'(r_n - 7'd1);
                n_state = khce_pkg::S_LAST;
            end
            khce_pkg::S_LAST: begin
                n_state = w_wrap ? khce_pkg::S_WDIV : khce_pkg::S_CLAMP;
            end
            khce_pkg::S_WDIV: begin
                if (w_div_done) begin
                    n_state = khce_pkg::S_WFIX;
                end
            end
            khce_pkg::S_WFIX: n_state = khce_pkg::S_CLAMP;
            khce_pkg::S_CLAMP: begin
                if (r_t < w_start || r_t > w_end) begin
                    n_state = khce_pkg::S_DONE;
                end else begin
                    n_state = khce_pkg::S_SISSUE;
                end
            end
            khce_pkg::S_SISSUE: begin
                if (r_count == 7'd0) begin
                    w_raddr = w_l7[5:0];
                    n_state = khce_pkg::S_GETL;
                end else begin
                    w_raddr = w_mid[5:0];
                    n_state = khce_pkg::S_SCMP;
                end
            end
            khce_pkg::S_SCMP: n_state = khce_pkg::S_SISSUE;
            khce_pkg::S_GETL: begin
                w_raddr = r_r;
                n_state = khce_pkg::S_GETR;
            end
            khce_pkg::S_GETR: n_state = khce_pkg::S_CHECK;
            khce_pkg::S_CHECK: begin
                n_state = w_hold ? khce_pkg::S_DONE : khce_pkg::S_M0;
            end
            khce_pkg::S_M0: begin
                if (w_mul_done) begin
                    n_state = khce_pkg::S_M1;
                end
            end
            khce_pkg::S_M1: begin
                if (w_mul_done) begin
                    n_state = khce_pkg::S_COEF;
                end
            end
            khce_pkg::S_COEF: n_state = khce_pkg::S_SPREP;
            khce_pkg::S_SPREP: begin
                if (w_dt > 33'sd0 && w_dt < r_dl) begin
                    n_state = khce_pkg::S_SDIV;
                end else begin
                    n_state = khce_pkg::S_HMUL;
                end
            end
            khce_pkg::S_SDIV: begin
                if (w_div_done) begin
                    n_state = khce_pkg::S_HMUL;
                end
            end
            khce_pkg::S_HMUL: begin
                if (w_mul_done && r_hk == 2'd2) begin
                    n_state = khce_pkg::S_DONE;
                end
            end
            khce_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = khce_pkg::S_IDLE;
                end
            end
            default: n_state = khce_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------- datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            khce_pkg::S_IDLE: begin
                r_n <= w_n_in;
                r_t <= {i_eval_time[31], i_eval_time};
            end
            khce_pkg::S_FIRST: begin
                r_start <= w_key.time_q;
                r_v0    <= w_key.value;
            end
            khce_pkg::S_LAST: begin
                r_end   <= w_key.time_q;
                r_vlast <= w_key.value;
                r_neg   <= w_diff[32];
                r_div_r <= '0;
                r_div_d <= w_diff[32] ? 33'(-w_diff) : 33'(w_diff);
                r_div_v <= 33'(w_len);
                r_div_cnt <= 6'd33;
            end
            khce_pkg::S_WDIV, khce_pkg::S_SDIV: begin
                if (!w_div_done) begin
                    r_div_r   <= w_div_ge ? 33'(w_div_rn - {1'b0, r_div_v}) : w_div_rn[32:0];
                    r_div_d   <= r_div_d << 1;
                    r_div_q   <= {r_div_q[14:0], w_div_ge};
                    r_div_cnt <= r_div_cnt - 6'd1;
                end else if (r_state == khce_pkg::S_SDIV) begin
                    r_s    <= {1'b0, r_div_q};
                    r_prod <= '0;
                    r_ma   <= {{(khce_pkg::PROD_W-48){r_ca[47]}}, r_ca};
                    r_mb   <= {16'd0, r_div_q};
                    r_hk   <= 2'd0;
                end
            end
            khce_pkg::S_WFIX: begin
                r_t <= w_start + $signed(w_rem);
            end
            khce_pkg::S_CLAMP: begin
                r_first <= '0;
                r_count <= r_n;
                if (r_t < w_start) begin
                    r_res_value <= r_v0;
                    r_res_seg   <= '0;
                end else begin
                    r_res_value <= r_vlast;
                    r_res_seg   <= 6'(r_n - 7'd1);
                end
            end
            khce_pkg::S_SISSUE: begin
                r_mid <= w_mid[5:0];
                r_l   <= w_l7[5:0];
                r_r   <= w_r7[5:0];
            end
            khce_pkg::S_SCMP: begin
                if (r_t < w_rd_time) begin
                    r_count <= w_half;
                end else begin
                    r_first <= {1'b0, r_mid} + 7'd1;
                    r_count <= r_count - w_half - 7'd1;
                end
            end
            khce_pkg::S_GETL: begin
                r_tl <= w_key.time_q;
                r_pl <= w_key.value;
                r_ol <= w_key.out_slope;
                r_fl <= w_key.flags;
            end
            khce_pkg::S_GETR: begin
                r_pr <= w_key.value;
                r_ir <= w_key.in_slope;
                r_fr <= w_key.flags;
                r_dl <= w_rd_time - {r_tl[31], r_tl};
            end
            khce_pkg::S_CHECK: begin
                r_res_value <= r_pl;
                r_res_seg   <= r_l;
                r_prod <= '0;
                r_ma   <= {{(khce_pkg::PROD_W-32){r_ol[31]}}, r_ol};
                r_mb   <= r_dl[31:0];
            end
            khce_pkg::S_M0, khce_pkg::S_M1, khce_pkg::S_HMUL: begin
                if (!w_mul_done) begin
                    if (r_mb[0]) begin
                        r_prod <= r_prod + r_ma;
                    end
                    r_ma <= r_ma <<< 1;
                    r_mb <= r_mb >> 1;
                end else if (r_state == khce_pkg::S_M0) begin
                    r_m0l  <= khce_pkg::sat48(w_prod_fl);
                    r_prod <= '0;
                    r_ma   <= {{(khce_pkg::PROD_W-32){r_ir[31]}}, r_ir};
                    r_mb   <= r_dl[31:0];
                end else if (r_state == khce_pkg::S_M1) begin
                    r_m1l <= khce_pkg::sat48(w_prod_fl);
                end else begin
                    // one Horner step done: fold in the next coefficient
                    r_hk   <= r_hk + 2'd1;
                    r_prod <= '0;
                    r_ma   <= {{(khce_pkg::PROD_W-48){w_h_next[47]}}, w_h_next};
                    r_mb   <= {15'd0, r_s};
                    r_res_value <= khce_pkg::sat32(w_h_next);
                end
            end
            khce_pkg::S_COEF: begin
                r_ca <= khce_pkg::sat48(w_a_sum);
                r_cb <= khce_pkg::sat48(w_b_sum);
            end
            khce_pkg::S_SPREP: begin
                r_div_r   <= 33'(w_dt);
                r_div_d   <= '0;
                r_div_v   <= 33'(r_dl);
                r_div_cnt <= 6'd16;
                r_prod    <= '0;
                r_ma      <= {{(khce_pkg::PROD_W-48){r_ca[47]}}, r_ca};
                r_hk      <= 2'd0;
                if (w_dt <= 33'sd0) begin
                    r_s  <= 17'd0;
                    r_mb <= 32'd0;
                end else begin
                    r_s  <= 17'h10000;
                    r_mb <= 32'h0001_0000;
                end
            end
            default: begin
            end
        endcase
    end

    // --------------------------------------------------------- output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            if (r_state == khce_pkg::S_DONE) begin
                r_out_value  <= r_res_value;
                r_out_status <= khce_pkg::STAT_OK;
                r_out_seg    <= r_res_seg;
            end else begin
                r_out_value  <= '0;
                r_out_status <= i_action ? khce_pkg::STAT_EMPTY : khce_pkg::STAT_LOADED;
                r_out_seg    <= '0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_curve_value   = r_out_value;
    assign o_status        = r_out_status;
    assign o_segment_index = r_out_seg;

endmodule

### sim/keyframe_hermite_curve_evaluator_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// keyframe_hermite_curve_evaluator_tb: self-checking bench for the key curve
// Loads key sets, evaluates the curve in clamp and loop modes with random
// stalls on both channels, and checks every result beat against a predictor.
// ---------------------------------------------------------------------------
module keyframe_hermite_curve_evaluator_tb;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;
    localparam int   CYCLE_LIMIT = 2000000;
    localparam int   RANDOM_ITEMS = 400;

    typedef struct {
        logic               action;
        logic [5:0]         idx;
        logic signed [31:0] kt;
        logic signed [31:0] kv;
        logic signed [31:0] kin;
        logic signed [31:0] kout;
        logic               in_step;
        logic               out_step;
        logic signed [31:0] et;
    } t_item;

    typedef struct {
        logic signed [31:0] value;
        logic [1:0]         status;
        logic [5:0]         seg;
    } t_result;

    logic               i_clk, i_rst_n;
    logic               i_in_valid, o_in_ready;
    logic               i_action;
    logic [5:0]         i_key_index;
    logic signed [31:0] i_key_time, i_key_value, i_key_in_slope, i_key_out_slope;
    logic               i_in_is_step, i_out_is_step;
    logic signed [31:0] i_eval_time;
    logic               o_out_valid, i_out_ready;
    logic signed [31:0] o_curve_value;
    logic [1:0]         o_status;
    logic [5:0]         o_segment_index;
    logic               psel, penable, pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata, prdata;
    logic               pready;

    keyframe_hermite_curve_evaluator i_dut (.*);

    // predictor copy of keys and registers
    logic signed [31:0] pk_time [64];
    logic signed [31:0] pk_value[64];
    logic signed [31:0] pk_in   [64];
    logic signed [31:0] pk_out  [64];
    logic [1:0]         pk_flags[64];
    logic [6:0]         cfg_key_count;
    logic               cfg_loop;

    // generator view of which slots hold a key and at what time
    bit                 slot_written[64];
    logic signed [31:0] gen_time[64];

    t_item   pending_items[$];
    t_result expected_results[$];
    int      mismatches;
    int      cycle_count;
    int      in_gap, out_hold;
    bit      quiet;
    int      item_total;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic int draw_wait();
        return quiet ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic longint clip48(longint x);
        if (x > 64'sd140737488355327) return 64'sd140737488355327;
        if (x < -64'sd140737488355328) return -64'sd140737488355328;
        return x;
    endfunction

    // floor(x * s / 2^16)
    function automatic longint frac_mul(longint x, longint s);
        longint hi, lo;
        hi = x >>> khce_pkg::FRAC_BITS;
        lo = x - (hi <<< khce_pkg::FRAC_BITS);
        return hi * s + ((lo * s) >>> khce_pkg::FRAC_BITS);
    endfunction

    function automatic logic signed [31:0] curve_at(int n, longint t, output int seg);
        longint start, stop, span, rem, first, count, half, mid;
        longint p0, p1, dl, m0l, m1l, ca, cb, dt, s, acc;
        int l, r;
        start = pk_time[0];
        stop = pk_time[n-1];
        span = stop - start;
        if (cfg_loop && span > 0 && (t < start || t > stop)) begin
            rem = (t - start) % span;
            if (rem < 0) rem += span;
            t = start + rem;
        end
        if (t < start) begin
            seg = 0;
            return pk_value[0];
        end
        if (t > stop) begin
            seg = n - 1;
            return pk_value[n-1];
        end
        first = 0;
        count = n;
        while (count > 0) begin
            half = count / 2;
            mid = first + half;
            if (t < pk_time[mid]) begin
                count = half;
            end else begin
                first = mid + 1;
                count -= half + 1;
            end
        end
        l = (first > 0) ? int'(first - 1) : 0;
        r = (first < n) ? int'(first) : n - 1;
        seg = l;
        p0 = pk_value[l];
        p1 = pk_value[r];
        dl = longint'(pk_time[r]) - longint'(pk_time[l]);
        if (dl <= 0 || pk_flags[l][1] || pk_flags[r][0]) return pk_value[l];
        m0l = clip48((longint'(pk_out[l]) * dl) >>> khce_pkg::FRAC_BITS);
        m1l = clip48((longint'(pk_in[r]) * dl) >>> khce_pkg::FRAC_BITS);
        ca = clip48(2 * (p0 - p1) + m0l + m1l);
        cb = clip48(3 * (p1 - p0) - 2 * m0l - m1l);
        dt = t - longint'(pk_time[l]);
        if (dt <= 0) s = 0;
        else if (dt >= dl) s = 64'sd1 <<< khce_pkg::FRAC_BITS;
        else s = (dt <<< khce_pkg::FRAC_BITS) / dl;
        acc = clip48(frac_mul(ca, s) + cb);
        acc = clip48(frac_mul(acc, s) + m0l);
        acc = clip48(frac_mul(acc, s) + p0);
        if (acc > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (acc < -64'sd2147483648) return 32'sh8000_0000;
        return acc[31:0];
    endfunction

    function automatic t_result apply_item(t_item it);
        t_result res;
        int n, seg;
        res.value = '0;
        res.seg = '0;
        if (it.action == ACT_LOAD) begin
            pk_time[it.idx] = it.kt;
            pk_value[it.idx] = it.kv;
            pk_in[it.idx] = it.kin;
            pk_out[it.idx] = it.kout;
            pk_flags[it.idx] = {it.out_step, it.in_step};
            res.status = khce_pkg::STAT_LOADED;
        end else begin
            n = (cfg_key_count > khce_pkg::MAX_KEYS) ? khce_pkg::MAX_KEYS
                                                     : int'(cfg_key_count);
            if (n == 0) begin
                res.status = khce_pkg::STAT_EMPTY;
            end else begin
                res.value = curve_at(n, longint'(it.et), seg);
                res.seg = seg[5:0];
                res.status = khce_pkg::STAT_OK;
            end
        end
        return res;
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_item it;
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                it.action = i_action;
                it.idx = i_key_index;
                it.kt = i_key_time;
                it.kv = i_key_value;
                it.kin = i_key_in_slope;
                it.kout = i_key_out_slope;
                it.in_step = i_in_is_step;
                it.out_step = i_out_is_step;
                it.et = i_eval_time;
                expected_results = {expected_results, apply_item(it)};
            end
            if (i_in_valid && !o_in_ready) begin
                // hold the beat
            end else if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                it = pending_items.pop_front();
                i_action <= it.action;
                i_key_index <= it.idx;
                i_key_time <= it.kt;
                i_key_value <= it.kv;
                i_key_in_slope <= it.kin;
                i_key_out_slope <= it.kout;
                i_in_is_step <= it.in_step;
                i_out_is_step <= it.out_step;
                i_eval_time <= it.et;
                i_in_valid <= 1'b1;
                in_gap = draw_wait();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor and result-side stalls
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_hold = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result beat value=%0d status=%0d seg=%0d",
                                 o_curve_value, o_status, o_segment_index);
                end else begin
                    want = expected_results.pop_front();
                    if (o_curve_value !== want.value || o_status !== want.status ||
                        o_segment_index !== want.seg) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: value %0d/%0d status %0d/%0d seg %0d/%0d (exp/act)",
                                     want.value, o_curve_value, want.status, o_status,
                                     want.seg, o_segment_index);
                    end
                end
                out_hold = draw_wait();
                i_out_ready <= (out_hold == 0);
            end else if (out_hold > 0) begin
                out_hold--;
                i_out_ready <= (out_hold == 0);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == khce_pkg::ADDR_KEY_COUNT) cfg_key_count = data[6:0];
        else cfg_loop = data[0];
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_regs(input int kc, input bit lp);
        write_reg(khce_pkg::ADDR_KEY_COUNT, kc);
        write_reg(khce_pkg::ADDR_LOOP, lp);
    endtask

    task automatic add_load(input int idx, input logic signed [31:0] t, v, sin, sout,
                            input bit ist, ost);
        t_item it;
        it = '{ACT_LOAD, idx[5:0], t, v, sin, sout, ist, ost, $urandom()};
        slot_written[idx] = 1'b1;
        gen_time[idx] = t;
        pending_items = {pending_items, it};
        item_total++;
    endtask

    task automatic add_eval(input logic signed [31:0] t);
        t_item it;
        it = '{ACT_EVAL, 6'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(),
               1'($urandom()), 1'($urandom()), t};
        pending_items = {pending_items, it};
        item_total++;
    endtask

    function automatic logic signed [31:0] rand_word(int mag);
        if ($urandom_range(0, 7) == 0) return $urandom();
        return $signed($urandom_range(0, 2 * mag)) - mag;
    endfunction

    // sorted key set in slots 0..n-1, with some zero-length and unsorted cases
    task automatic load_set(input int n);
        longint t;
        bit wild;
        wild = ($urandom_range(0, 9) == 0);
        t = rand_word(1 << 22);
        for (int i = 0; i < n; i++) begin
            add_load(i, wild ? $urandom() : t[31:0], rand_word(1 << 24), rand_word(1 << 18),
                     rand_word(1 << 18), $urandom_range(0, 7) == 0,
                     $urandom_range(0, 7) == 0);
            case ($urandom_range(0, 7))
                0: t = t;
                1: t = t + $urandom_range(1, 16);
                default: t = t + $urandom_range(1, 1 << 18);
            endcase
            if (t > 64'sd2147483647) t = 64'sd2147483647;
        end
    endtask

    function automatic logic signed [31:0] pick_time(int n);
        longint lo, hi, span;
        int k;
        k = $urandom_range(0, n - 1);
        lo = gen_time[0];
        hi = gen_time[n-1];
        if (hi < lo) begin
            span = lo;
            lo = hi;
            hi = span;
        end
        span = hi - lo + 1;
        case ($urandom_range(0, 5))
            0: return gen_time[k];
            1: return gen_time[k] + ($urandom_range(0, 1) ? 1 : -1);
            2: return $urandom();
            default: begin
                lo = lo - span;
                hi = hi + span;
                if (lo < -64'sd2147483648) lo = -64'sd2147483648;
                if (hi > 64'sd2147483647) hi = 64'sd2147483647;
                return 32'(lo + longint'({$urandom(), $urandom()} % 64'(hi - lo + 1)));
            end
        endcase
    endfunction

    initial begin
        int n, kc, evals;
        bit ok;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_ready = 1'b0;
        i_action = ACT_LOAD;
        i_key_index = '0;
        i_key_time = '0;
        i_key_value = '0;
        i_key_in_slope = '0;
        i_key_out_slope = '0;
        i_in_is_step = 1'b0;
        i_out_is_step = 1'b0;
        i_eval_time = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_key_count = '0;
        cfg_loop = 1'b0;
        mismatches = 0;
        cycle_count = 0;
        item_total = 0;
        quiet = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty curve, extreme field values
        add_eval(32'sh8000_0000);
        add_eval(32'sh7FFF_FFFF);
        add_load(63, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1, 1);
        add_load(62, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0);
        drain();

        // steps, zero-length segment, huge tangents, exact end times, looping
        set_regs(4, 1);
        add_load(0, 32'sh0, 32'sh10000, 32'sh0, 32'sh7FFF_FFFF, 0, 0);
        add_load(1, 32'sh10000, 32'sh7FFF_0000, 32'sh8000_0000, 32'sh0, 0, 1);
        add_load(2, 32'sh10000, 32'sh8000_0000, 32'sh0, 32'sh8000, 0, 0);
        add_load(3, 32'sh30000, 32'sh20000, 32'sh10000, 32'sh0, 1, 0);
        add_eval(32'sh8000);
        add_eval(32'sh18000);
        add_eval(32'sh30000);
        add_eval(32'sh0);
        add_eval(32'sh7FFF_FFFF);
        add_eval(32'sh8000_0000);
        add_eval(-32'sh8000);
        drain();
        set_regs(4, 0);
        add_eval(-32'sh8000);
        add_eval(32'sh40000);
        add_eval(32'sh10000);
        drain();

        // looping over a negative range, then over a single key
        set_regs(2, 1);
        add_load(0, 32'sh50000, 32'sh1234, 32'sh0, 32'sh0, 0, 0);
        add_load(1, 32'sh20000, 32'sh5678, 32'sh0, 32'sh0, 0, 0);
        add_eval(32'sh60000);
        add_eval(32'sh30000);
        drain();
        set_regs(1, 1);
        add_eval(32'sh8000_0000);
        add_eval(32'sh50000);
        drain();

        while (item_total < RANDOM_ITEMS + 25) begin
            quiet = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 15))
                0: kc = 0;
                1: kc = 64;
                2: kc = 100;
                3: kc = 127;
                default: kc = $urandom_range(1, 9);
            endcase
            n = (kc > khce_pkg::MAX_KEYS) ? khce_pkg::MAX_KEYS : kc;
            set_regs(kc, $urandom_range(0, 1));
            ok = 1'b1;
            for (int i = 0; i < n; i++) ok &= slot_written[i];
            if (n > 0 && (!ok || (n < 64 ? $urandom_range(0, 3) != 0
                                         : $urandom_range(0, 3) == 0)))
                load_set(n);
            evals = $urandom_range(10, 25);
            for (int i = 0; i < evals; i++) begin
                if ($urandom_range(0, 7) == 0)
                    add_load($urandom_range(0, 63), $urandom(), $urandom(), $urandom(),
                             $urandom(), $urandom_range(0, 1), $urandom_range(0, 1));
                else
                    add_eval(n > 0 ? pick_time(n) : $urandom());
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
